### hdl/cdt_pkg.sv
package cdt_pkg;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_POLL     = 2'd2,
    OP_NOP      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_NOT_PEND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CHK,
    S_ADD_WR,
    S_CMP_RD,
    S_CMP_CHK,
    S_FINAL
  } state_e;

  localparam int unsigned IdW   = 5;
  localparam int unsigned SlotN = 8;

  typedef struct packed {
    logic [1:0]     operation;
    logic [IdW-1:0] cmd_id;
    logic [3:0]     dep_count;
    logic [IdW-1:0] dep_id_0;
    logic [IdW-1:0] dep_id_1;
    logic [IdW-1:0] dep_id_2;
    logic [IdW-1:0] dep_id_3;
    logic [IdW-1:0] dep_id_4;
    logic [IdW-1:0] dep_id_5;
    logic [IdW-1:0] dep_id_6;
    logic [IdW-1:0] dep_id_7;
    logic           mailbox_free;
  } cmd_t;

  typedef struct packed {
    logic           ready_valid;
    logic [IdW-1:0] ready_id;
    logic           mask_valid;
    logic [31:0]    completed_mask;
    logic [1:0]     status;
    logic           last;
  } res_t;

endpackage

### hdl/command_dependency_tracker.sv
// Add and complete step through the sequencer states; poll and nop answer
// combinationally (result in the accept cycle).
// One item in flight; busy_o is high from accept until the final result.
// Each dependency or forward entry takes one check and one table step on a
// single shared counter/compare path. Results are strobed one cycle each.
// Reset (async, active low) clears pending, wait/forward counts and the mask;
// the forward list memory is not cleared.
module command_dependency_tracker
  import cdt_pkg::*;
#(
  parameter int unsigned NUM_IDS  = 32,
  parameter int unsigned MAX_DEPS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);
  localparam int unsigned DW = $clog2(MAX_DEPS + 1);
  localparam int unsigned KW = (MAX_DEPS > 1) ? $clog2(MAX_DEPS) : 1;
  localparam int unsigned FL = NUM_IDS * MAX_DEPS;
  localparam int unsigned AW = (FL > 1) ? $clog2(FL) : 1;

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic [NUM_IDS-1:0] pend_q;
  logic [DW-1:0] wait_q [NUM_IDS];
  logic [DW-1:0] fwd_q [NUM_IDS];
  logic [DW-1:0] extra_q [NUM_IDS];
  logic [31:0] done_q;
  logic [IdW-1:0] fl_mem [FL];
  logic [IdW-1:0] rd_q;
  logic [3:0] idx_q;
  logic [DW-1:0] cnt_q, waits_q;
  logic [MAX_DEPS-1:0] use_q;

  // dependency slot select
  logic [IdW-1:0] slots [SlotN];
  assign slots = '{cmd_q.dep_id_0, cmd_q.dep_id_1, cmd_q.dep_id_2, cmd_q.dep_id_3,
                   cmd_q.dep_id_4, cmd_q.dep_id_5, cmd_q.dep_id_6, cmd_q.dep_id_7};
  logic [IdW-1:0] dsel;
  logic [KW-1:0] k;
  assign k    = idx_q[KW-1:0];
  assign dsel = slots[idx_q[2:0]];
  logic d_in, d_live, d_full;
  // a slot only counts when its ID is in range, not the command itself, and pending
  assign d_in   = 32'(dsel) < NUM_IDS;
  assign d_live = cnt_q != '0 && d_in && dsel != cmd_q.cmd_id &&
                  pend_q[dsel[$clog2(NUM_IDS)-1:0]];
  assign d_full = d_live && (32'(fwd_q[dsel[$clog2(NUM_IDS)-1:0]]) +
                  32'(extra_q[dsel[$clog2(NUM_IDS)-1:0]]) + 1 > MAX_DEPS);

  localparam int unsigned NW = $clog2(NUM_IDS);
  logic [NW-1:0] cid, did, rid;
  assign cid = cmd_q.cmd_id[NW-1:0];
  assign did = dsel[NW-1:0];
  assign rid = rd_q[NW-1:0];
  logic id_ok;
  assign id_ok = 32'(cmd_q.cmd_id) < NUM_IDS;
  logic r_live;
  assign r_live = 32'(rd_q) < NUM_IDS && pend_q[rid] && wait_q[rid] != '0;
  logic [3:0] dc_sat;
  assign dc_sat = (32'(cmd_i.dep_count) > MAX_DEPS) ? 4'(MAX_DEPS) : cmd_i.dep_count;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) begin
        unique case (cmd_i.operation)
          OP_ADD:      state_d = S_ADD_CHK;
          OP_COMPLETE: state_d = S_CMP_RD;
          default:     state_d = S_IDLE;
        endcase
      end
      S_ADD_CHK: begin
        if (!id_ok || pend_q[cid] || done_q[cid] || d_full) state_d = S_IDLE;
        else if (4'(idx_q) + 1 >= 4'(cnt_q) || cnt_q == '0) state_d = S_ADD_WR;
      end
      S_ADD_WR: if (4'(idx_q) + 1 >= 4'(cnt_q) || cnt_q == '0) state_d = S_IDLE;
      S_CMP_RD: begin
        if (!id_ok || !pend_q[cid]) state_d = S_IDLE;
        else if (4'(idx_q) >= 4'(fwd_q[cid])) state_d = S_FINAL;
        else state_d = S_CMP_CHK;
      end
      S_CMP_CHK: state_d = S_CMP_RD;
      S_FINAL:   state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res_valid_o = 1'b0;
    res_o = '0;
    busy_o = state_q != S_IDLE;
    unique case (state_q)
      S_IDLE: if (start_i && cmd_i.operation == OP_POLL) begin
        res_valid_o = 1'b1;
        res_o.last = 1'b1;
        if (done_q != '0 && cmd_i.mailbox_free) begin
          res_o.mask_valid = 1'b1;
          res_o.completed_mask = done_q;
        end
      end else if (start_i && cmd_i.operation == OP_NOP) begin
        res_valid_o = 1'b1;
        res_o.last = 1'b1;
      end
      S_ADD_CHK: begin
        res_o.ready_id = cmd_q.cmd_id;
        res_o.last = 1'b1;
        if (!id_ok || pend_q[cid] || done_q[cid]) begin
          res_valid_o = 1'b1;
          res_o.status = ST_BUSY;
        end else if (d_full) begin
          res_valid_o = 1'b1;
          res_o.status = ST_FULL;
        end
      end
      S_ADD_WR: if (4'(idx_q) + 1 >= 4'(cnt_q) || cnt_q == '0) begin
        res_valid_o = 1'b1;
        res_o.ready_id = cmd_q.cmd_id;
        res_o.last = 1'b1;
        res_o.ready_valid = (waits_q + DW'(cnt_q != '0 && use_q[k])) == '0;
      end
      S_CMP_RD: if (!id_ok || !pend_q[cid]) begin
        res_valid_o = 1'b1;
        res_o.ready_id = cmd_q.cmd_id;
        res_o.status = ST_NOT_PEND;
        res_o.last = 1'b1;
      end
      S_CMP_CHK: if (r_live && wait_q[rid] == DW'(1)) begin
        res_valid_o = 1'b1;
        res_o.ready_valid = 1'b1;
        res_o.ready_id = rd_q;
      end
      S_FINAL: begin
        res_valid_o = 1'b1;
        res_o.last = 1'b1;
        if (cmd_q.mailbox_free) begin
          res_o.mask_valid = 1'b1;
          res_o.completed_mask = done_q | (32'd1 << cmd_q.cmd_id);
        end
      end
      default: ;
    endcase
  end

  // forward list memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_ADD_WR && cnt_q != '0 && use_q[k])
      fl_mem[AW'(32'(slots[idx_q[2:0]]) * MAX_DEPS + 32'(fwd_q[did]))] <= cmd_q.cmd_id;
    rd_q <= fl_mem[AW'(32'(cid) * MAX_DEPS + 32'(idx_q[KW-1:0]))];
  end

  // sequencer and tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= '0;
      done_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      waits_q <= '0;
      use_q   <= '0;
      cmd_q   <= '0;
      for (int i = 0; i < NUM_IDS; i++) begin
        wait_q[i] <= '0;
        fwd_q[i] <= '0;
        extra_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (start_i) begin
          cmd_q <= cmd_i;
          idx_q <= '0;
          cnt_q <= DW'(dc_sat);
          waits_q <= '0;
          use_q <= '0;
          for (int i = 0; i < NUM_IDS; i++) extra_q[i] <= '0;
          if (cmd_i.operation == OP_POLL && cmd_i.mailbox_free) done_q <= '0;
        end
        S_ADD_CHK: begin
          if (cnt_q != '0 && d_live) begin
            extra_q[did] <= extra_q[did] + 1'b1;
            use_q[k] <= 1'b1;
          end
          if (state_d == S_ADD_WR) idx_q <= '0;
          else idx_q <= idx_q + 1'b1;
        end
        S_ADD_WR: begin
          if (cnt_q != '0 && use_q[k]) begin
            fwd_q[did] <= fwd_q[did] + 1'b1;
            waits_q <= waits_q + 1'b1;
          end
          idx_q <= idx_q + 1'b1;
          if (state_d == S_IDLE) begin
            pend_q[cid] <= 1'b1;
            wait_q[cid] <= waits_q + DW'(cnt_q != '0 && use_q[k]);
          end
        end
        S_CMP_CHK: begin
          if (r_live) wait_q[rid] <= wait_q[rid] - 1'b1;
          idx_q <= idx_q + 1'b1;
        end
        S_FINAL: begin
          pend_q[cid] <= 1'b0;
          wait_q[cid] <= '0;
          fwd_q[cid] <= '0;
          done_q <= cmd_q.mailbox_free ? '0 : (done_q | (32'd1 << cmd_q.cmd_id));
        end
        default: ;
      endcase
    end
  end
endmodule

### hdl/cdt_checker.sv
module cdt_checker
  import cdt_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic res_valid_o,
  input res_t res_o
);
  a_mask_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.mask_valid |-> res_o.completed_mask == '0)
    else $error("mask without flag");
  a_ready_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> res_o.ready_valid && res_o.status == ST_OK)
    else $error("bad intermediate result");
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !busy_o)
    else $error("busy after last");
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> busy_o)
    else $error("dropped busy mid item");
  // idle with no transfer offered means no result
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !start_i |-> !res_valid_o)
    else $error("result while idle");
endmodule

bind command_dependency_tracker cdt_checker u_cdt_checker (.*);

### dv/command_dependency_tracker_test.sv
`timescale 1ns / 100ps

module command_dependency_tracker_test;
  import cdt_pkg::*;

  localparam int unsigned NumIds    = 32;
  localparam int unsigned MaxDeps   = 8;
  localparam int unsigned CycleCap  = 400000;
  localparam int unsigned RandItems = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  cmd_t cmd_i = '0;
  logic res_valid_o;
  res_t res_o;

  command_dependency_tracker uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  bit             pend_q[NumIds];
  bit [3:0]       wait_q[NumIds];
  bit [3:0]       fwd_cnt_q[NumIds];
  bit [IdW-1:0]   fwd_list_q[NumIds*MaxDeps];
  bit [31:0]      done_q;

  res_t           expected_results[$];
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;

  // directed stimulus, typed result only where obvious
  typedef struct {
    cmd_t cmd;
    bit   typed;
    res_t res;
  } row_t;
  row_t dir_rows[$];

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [IdW-1:0] dep_of(input cmd_t c, input int k);
    logic [IdW-1:0] d[8];
    d = '{c.dep_id_0, c.dep_id_1, c.dep_id_2, c.dep_id_3,
          c.dep_id_4, c.dep_id_5, c.dep_id_6, c.dep_id_7};
    return d[k];
  endfunction

  function automatic res_t make_res(input bit rv, input logic [IdW-1:0] rid, input bit mv,
                                    input logic [31:0] m, input status_e st, input bit lst);
    res_t r;
    r.ready_valid = rv;
    r.ready_id = rid;
    r.mask_valid = mv;
    r.completed_mask = m;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  // compute results of one accepted command and update tracker state
  task automatic track_command(input cmd_t c);
    int unsigned extra[NumIds];
    int unsigned preds[$];
    int unsigned cnt, d, waits;
    logic [IdW-1:0] id;
    id = c.cmd_id;
    case (op_e'(c.operation))
      OP_ADD: begin
        if (pend_q[id] || done_q[id]) begin
          expected_results.push_back(make_res(0, id, 0, '0, ST_BUSY, 1));
          return;
        end
        cnt = (c.dep_count > MaxDeps) ? MaxDeps : c.dep_count;
        foreach (extra[i]) extra[i] = 0;
        for (int k = 0; k < cnt; k++) begin
          d = dep_of(c, k);
          if (d == id || !pend_q[d]) continue;
          extra[d]++;
          if (fwd_cnt_q[d] + extra[d] > MaxDeps) begin
            expected_results.push_back(make_res(0, id, 0, '0, ST_FULL, 1));
            return;
          end
          preds.push_back(d);
        end
        waits = 0;
        foreach (preds[i]) begin
          fwd_list_q[preds[i]*MaxDeps + fwd_cnt_q[preds[i]]] = id;
          fwd_cnt_q[preds[i]]++;
          waits++;
        end
        pend_q[id] = 1;
        wait_q[id] = 4'(waits);
        expected_results.push_back(make_res(waits == 0, id, 0, '0, ST_OK, 1));
      end
      OP_COMPLETE: begin
        if (!pend_q[id]) begin
          expected_results.push_back(make_res(0, id, 0, '0, ST_NOT_PEND, 1));
          return;
        end
        for (int k = 0; k < fwd_cnt_q[id]; k++) begin
          d = fwd_list_q[id*MaxDeps + k];
          if (!pend_q[d] || wait_q[d] == 0) continue;
          wait_q[d]--;
          if (wait_q[d] == 0)
            expected_results.push_back(make_res(1, IdW'(d), 0, '0, ST_OK, 0));
        end
        pend_q[id] = 0;
        wait_q[id] = 0;
        fwd_cnt_q[id] = 0;
        done_q[id] = 1'b1;
        if (c.mailbox_free) begin
          expected_results.push_back(make_res(0, '0, 1, done_q, ST_OK, 1));
          done_q = '0;
        end else begin
          expected_results.push_back(make_res(0, '0, 0, '0, ST_OK, 1));
        end
      end
      OP_POLL: begin
        if (done_q != 0 && c.mailbox_free) begin
          expected_results.push_back(make_res(0, '0, 1, done_q, ST_OK, 1));
          done_q = '0;
        end else begin
          expected_results.push_back(make_res(0, '0, 0, '0, ST_OK, 1));
        end
      end
      default: expected_results.push_back(make_res(0, '0, 0, '0, ST_OK, 1));
    endcase
  endtask

  function automatic cmd_t build_cmd(input op_e op, input int unsigned id, input int unsigned n,
                                     input int unsigned d0, input int unsigned d1,
                                     input bit mb);
    cmd_t c;
    c = '0;
    c.operation = op;
    c.cmd_id = IdW'(id);
    c.dep_count = 4'(n);
    c.dep_id_0 = IdW'(d0);
    c.dep_id_1 = IdW'(d1);
    c.dep_id_2 = IdW'(d1);
    c.dep_id_3 = IdW'(d0);
    c.dep_id_4 = IdW'(d0);
    c.dep_id_5 = IdW'(d0);
    c.dep_id_6 = IdW'(d0);
    c.dep_id_7 = IdW'(d0);
    c.mailbox_free = mb;
    return c;
  endfunction

  // random command biased toward live IDs
  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    c = '0;
    c.cmd_id = IdW'($urandom_range(0, NumIds - 1));
    c.dep_count = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                 : $urandom_range(0, 4));
    c.dep_id_0 = IdW'($urandom);
    c.dep_id_1 = IdW'($urandom);
    c.dep_id_2 = IdW'($urandom);
    c.dep_id_3 = IdW'($urandom);
    c.dep_id_4 = IdW'($urandom);
    c.dep_id_5 = IdW'($urandom);
    c.dep_id_6 = IdW'($urandom);
    c.dep_id_7 = IdW'($urandom);
    c.mailbox_free = $urandom_range(0, 3) != 0;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.operation = OP_ADD;
      // mostly fresh IDs and pending predecessors
      for (int t = 0; t < 8; t++) begin
        if (!pend_q[c.cmd_id] && !done_q[c.cmd_id]) break;
        c.cmd_id = IdW'($urandom_range(0, NumIds - 1));
      end
      for (int k = 0; k < 8; k++) begin
        pick = $urandom_range(0, NumIds - 1);
        if (pend_q[pick] && $urandom_range(0, 3) != 0) begin
          case (k)
            0: c.dep_id_0 = IdW'(pick);
            1: c.dep_id_1 = IdW'(pick);
            2: c.dep_id_2 = IdW'(pick);
            3: c.dep_id_3 = IdW'(pick);
            4: c.dep_id_4 = IdW'(pick);
            5: c.dep_id_5 = IdW'(pick);
            6: c.dep_id_6 = IdW'(pick);
            default: c.dep_id_7 = IdW'(pick);
          endcase
        end
      end
    end else if (pick < 85) begin
      c.operation = OP_COMPLETE;
      for (int t = 0; t < 10; t++) begin
        if (pend_q[c.cmd_id]) break;
        c.cmd_id = IdW'($urandom_range(0, NumIds - 1));
      end
    end else if (pick < 95) begin
      c.operation = OP_POLL;
    end else begin
      c.operation = OP_NOP;
    end
    return c;
  endfunction

  // one transfer: hold start until the edge that accepts it; predict before that edge
  task automatic send_command(input cmd_t c);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    track_command(c);
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", res_o));
      end else begin
        exp_r = expected_results.pop_front();
        if (res_o.ready_valid !== exp_r.ready_valid)
          report_mismatch($sformatf("ready_valid %b exp %b", res_o.ready_valid, exp_r.ready_valid));
        if (res_o.ready_id !== exp_r.ready_id)
          report_mismatch($sformatf("ready_id %0d exp %0d", res_o.ready_id, exp_r.ready_id));
        if (res_o.mask_valid !== exp_r.mask_valid)
          report_mismatch($sformatf("mask_valid %b exp %b", res_o.mask_valid, exp_r.mask_valid));
        if (res_o.completed_mask !== exp_r.completed_mask)
          report_mismatch($sformatf("mask %h exp %h", res_o.completed_mask,
                                    exp_r.completed_mask));
        if (res_o.status !== exp_r.status)
          report_mismatch($sformatf("status %0d exp %0d", res_o.status, exp_r.status));
        if (res_o.last !== exp_r.last)
          report_mismatch($sformatf("last %b exp %b", res_o.last, exp_r.last));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t r;
    res_t got;
    foreach (pend_q[i]) begin
      pend_q[i] = 0;
      wait_q[i] = 0;
      fwd_cnt_q[i] = 0;
    end
    done_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: 0 = no check typed, otherwise typed result checked against predictor
    dir_rows.push_back('{build_cmd(OP_POLL, 0, 0, 0, 0, 1), 1,
                         make_res(0, '0, 0, '0, ST_OK, 1)});
    dir_rows.push_back('{build_cmd(OP_NOP, 31, 15, 31, 31, 1), 1,
                         make_res(0, '0, 0, '0, ST_OK, 1)});
    dir_rows.push_back('{build_cmd(OP_COMPLETE, 31, 0, 0, 0, 1), 1,
                         make_res(0, 5'd31, 0, '0, ST_NOT_PEND, 1)});
    dir_rows.push_back('{build_cmd(OP_ADD, 0, 0, 0, 0, 1), 1,
                         make_res(1, 5'd0, 0, '0, ST_OK, 1)});
    dir_rows.push_back('{build_cmd(OP_ADD, 0, 0, 0, 0, 1), 1,
                         make_res(0, 5'd0, 0, '0, ST_BUSY, 1)});
    // self and absent predecessors count as done
    dir_rows.push_back('{build_cmd(OP_ADD, 31, 2, 31, 5, 0), 1,
                         make_res(1, 5'd31, 0, '0, ST_OK, 1)});
    // duplicate predecessor, saturating count: eight slots on ID 0
    dir_rows.push_back('{build_cmd(OP_ADD, 1, 15, 0, 0, 0), 1,
                         make_res(0, 5'd1, 0, '0, ST_OK, 1)});
    // forward list of ID 0 is full
    dir_rows.push_back('{build_cmd(OP_ADD, 2, 1, 0, 0, 0), 1,
                         make_res(0, 5'd2, 0, '0, ST_FULL, 1)});
    dir_rows.push_back('{build_cmd(OP_ADD, 3, 2, 31, 1, 1), 0, '0});
    dir_rows.push_back('{build_cmd(OP_ADD, 4, 1, 3, 3, 1), 0, '0});
    // early complete of a waiting command
    dir_rows.push_back('{build_cmd(OP_COMPLETE, 3, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{build_cmd(OP_COMPLETE, 0, 0, 0, 0, 0), 0, '0});
    // busy because completed but unreported
    dir_rows.push_back('{build_cmd(OP_ADD, 0, 0, 0, 0, 1), 1,
                         make_res(0, 5'd0, 0, '0, ST_BUSY, 1)});
    dir_rows.push_back('{build_cmd(OP_POLL, 0, 0, 0, 0, 0), 0, '0});
    dir_rows.push_back('{build_cmd(OP_POLL, 0, 0, 0, 0, 1), 0, '0});
    dir_rows.push_back('{build_cmd(OP_COMPLETE, 31, 0, 0, 0, 1), 0, '0});
    dir_rows.push_back('{build_cmd(OP_COMPLETE, 1, 0, 0, 0, 1), 0, '0});
    dir_rows.push_back('{build_cmd(OP_COMPLETE, 4, 0, 0, 0, 1), 0, '0});
    dir_rows.push_back('{build_cmd(OP_POLL, 0, 0, 0, 0, 1), 1,
                         make_res(0, '0, 0, '0, ST_OK, 1)});

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_command(r.cmd);
      if (r.typed) begin
        got = expected_results[expected_results.size() - 1];
        if (got !== r.res)
          report_mismatch($sformatf("directed row %0d predicts %h, table %h", i, got, r.res));
      end
    end

    for (int n = 0; n < RandItems; n++) send_command(random_cmd());
    start_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
